[rtl/core/ssq_pkg.sv]
// Shared types, sizes and codes for the searchable shift queue.
// No dependencies; every other file in rtl/core imports this package.
package ssq_pkg;

  localparam int DEPTH = 64;                  // storage positions, 2 to 64
  localparam int CNT_W = $clog2(DEPTH + 1);   // fill count, holds DEPTH itself
  localparam int IDX_W = $clog2(DEPTH);       // position index into storage

  localparam int FUNC_W = 2;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;
  localparam int POS_W  = 6;

  // command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  localparam logic [FUNC_W-1:0] FUNC_ENQ    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STAT_W-1:0] ST_MATCH     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOMATCH   = 3'd4;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_DEQ,
    OP_SEARCH
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] data;
    logic [POS_W-1:0]        position;
    logic                    last;
  } result_t;

endpackage

[rtl/core/ssq_in_if.sv]
// Input channel of the searchable shift queue: valid/ready plus func and value.
// Depends on ssq_pkg.
interface ssq_in_if;
  import ssq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

[rtl/core/ssq_out_if.sv]
// Result channel of the searchable shift queue: valid/ready plus result fields.
// Depends on ssq_pkg.
interface ssq_out_if;
  import ssq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] data;
  logic [POS_W-1:0]        position;
  logic                    last;

  modport source (output valid, output status, output data, output position,
                  output last, input ready);
  modport sink   (input valid, input status, input data, input position,
                  input last, output ready);
endinterface

[rtl/core/ssq_front.sv]
// Front end: accepts input transfers, decodes func and buffers commands.
// Depends on ssq_pkg and ssq_in_if.
module ssq_front (
  input  logic          clk,
  input  logic          rst_n,
  ssq_in_if.sink        in_ch,
  output ssq_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_pop
);
  import ssq_pkg::*;

  cmd_t                q_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r;
  logic [CQ_PTR_W-1:0] rd_ptr_r;
  logic [CQ_CNT_W-1:0] cnt_r;

  logic accept;
  logic keep;
  op_t  op_dec;
  logic push;
  logic pop;

  always_comb begin
    keep   = 1'b1;
    op_dec = OP_ENQ;
    unique case (in_ch.func)
      FUNC_ENQ:    op_dec = OP_ENQ;
      FUNC_DEQ:    op_dec = OP_DEQ;
      FUNC_SEARCH: op_dec = OP_SEARCH;
      default:     keep   = 1'b0;   // unused selector: swallowed here
    endcase
  end

  assign in_ch.ready = (cnt_r != CQ_CNT_W'(CQ_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && keep;
  assign pop         = cmd_pop && cmd_valid;

  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        q_r[wr_ptr_r] <= '{op: op_dec, value: in_ch.value};
        wr_ptr_r      <= (wr_ptr_r == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/ssq_back.sv]
// Back end: shifting word store, fill count, match scan and result register.
// Depends on ssq_pkg and ssq_out_if.
module ssq_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ssq_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  ssq_out_if.source     out_ch
);
  import ssq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                  state_r;
  logic signed [VAL_W-1:0] entries_r [DEPTH];
  logic [CNT_W-1:0]        count_r;
  logic [DEPTH-1:0]        match_r;
  logic signed [VAL_W-1:0] key_r;
  logic                    out_valid_r;
  result_t                 out_res_r;

  logic             out_free;
  logic             out_load;
  logic [DEPTH-1:0] hit;
  logic [DEPTH-1:0] match_rest;
  logic [IDX_W-1:0] first_idx;

  assign out_free = !out_valid_r || out_ch.ready;
  assign cmd_pop  = (state_r == S_IDLE) && cmd_valid && out_free;
  // a result is loaded for every enqueue and dequeue, and once per scan step
  assign out_load = (cmd_pop && (cmd.op != OP_SEARCH)) || ((state_r == S_SCAN) && out_free);

  // compare the key against every held word at once
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit[i] = (entries_r[i] == cmd.value) && (CNT_W'(i) < count_r);
    end
  end

  always_comb begin
    first_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_r[i]) first_idx = IDX_W'(i);
    end
  end

  // drop the lowest set bit
  assign match_rest = match_r & (match_r - DEPTH'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (cmd_pop) begin
            unique case (cmd.op)
              OP_ENQ: begin
                if (count_r == CNT_W'(DEPTH)) begin
                  out_res_r <= '{status: ST_OVERFLOW, data: '0, position: '0, last: 1'b1};
                end else begin
                  entries_r[count_r[IDX_W-1:0]] <= cmd.value;
                  count_r   <= count_r + 1'b1;
                  out_res_r <= '{status: ST_OK, data: '0, position: '0, last: 1'b1};
                end
              end
              OP_DEQ: begin
                if (count_r == '0) begin
                  out_res_r <= '{status: ST_UNDERFLOW, data: '0, position: '0, last: 1'b1};
                end else begin
                  for (int i = 0; i < DEPTH - 1; i++) begin
                    entries_r[i] <= entries_r[i + 1];
                  end
                  count_r   <= count_r - 1'b1;
                  out_res_r <= '{status: ST_OK, data: entries_r[0], position: '0,
                                 last: 1'b1};
                end
              end
              OP_SEARCH: begin
                match_r <= hit;
                key_r   <= cmd.value;
                state_r <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (out_free) begin
            if (match_r == '0) begin
              out_res_r <= '{status: ST_NOMATCH, data: '0, position: '0, last: 1'b1};
              state_r   <= S_IDLE;
            end else begin
              // a matching word equals the key, so the key is returned
              out_res_r <= '{status: ST_MATCH, data: key_r, position: POS_W'(first_idx),
                             last: (match_rest == '0)};
              match_r   <= match_rest;
              if (match_rest == '0) state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_res_r.status;
  assign out_ch.data     = out_res_r.data;
  assign out_ch.position = out_res_r.position;
  assign out_ch.last     = out_res_r.last;

endmodule

[rtl/core/searchable_shift_queue.sv]
// Top level of the searchable shift queue: front decoder, command queue, back end.
// Depends on ssq_pkg, ssq_in_if, ssq_out_if, ssq_front and ssq_back.
//
//   channel  dir  fields                          transfer when
//   in_ch    in   func, value                     valid && ready
//   out_ch   out  status, data, position, last    valid && ready
//
// The back end handles an enqueue or dequeue as soon as it pops it, so with the
// result taken every cycle one item transfers per cycle.
// A search first compares the key against every held word into the match vector,
// then gives one result per match off it, or a single no-match result if none.
// Commands pass through the command queue (2 entries), then the result register.
// Reset (rst_n low, synchronous) empties the queue and the command buffer.
// A stalled output holds the back end; input stalls once the command queue fills.
module searchable_shift_queue (
  input logic        clk,
  input logic        rst_n,
  ssq_in_if.sink     in_ch,
  ssq_out_if.source  out_ch
);
  import ssq_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  ssq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  ssq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

endmodule

[verif/tb.sv]
// Self-checking bench for searchable_shift_queue: clocked driver and monitor around
// a behavioural mirror of the queue, with directed then randomised operations.
// Depends on ssq_pkg, ssq_in_if, ssq_out_if and the searchable_shift_queue RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssq_pkg::*;

  localparam logic [FUNC_W-1:0]     FUNC_NONE   = 2'd3;  // unused selector, dropped
  localparam logic signed [VAL_W-1:0] WORD_MIN  = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] WORD_MAX  = 32'sh7FFF_FFFF;
  localparam int unsigned           LONG_HOLD   = 150;
  localparam int unsigned           TAIL_CYCLES = 20;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic signed [VAL_W-1:0] value;
    logic [7:0]              gap;    // idle cycles after this transfer
  } request_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ssq_in_if  in_ch ();
  ssq_out_if out_ch ();

  searchable_shift_queue uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  request_t                requests[$];
  request_t                next_rq;
  result_t                 due_results[$];
  result_t                 want;
  logic signed [VAL_W-1:0] mirror_words[$];
  logic signed [VAL_W-1:0] word_pool[8];
  int unsigned             gen_fill;
  bit                      gen_calm;
  int unsigned             idle_left;
  int unsigned             stall_left;
  int unsigned             ops_done;
  int unsigned             results_checked;
  int unsigned             errors;
  int unsigned             overflows;
  int unsigned             underflows;
  int                      widest_search;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned idle_len(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_word();
    if ($urandom_range(0, 9) < 6) return word_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic add_op(input logic [FUNC_W-1:0] f, input logic signed [VAL_W-1:0] v);
    request_t rq;
    rq.func  = f;
    rq.value = v;
    rq.gap   = 8'(idle_len(gen_calm));
    requests.push_back(rq);
    if (f == FUNC_ENQ && gen_fill < DEPTH) gen_fill++;
    else if (f == FUNC_DEQ && gen_fill > 0) gen_fill--;
  endtask

  task automatic push_result(input logic [STAT_W-1:0] st, input logic signed [VAL_W-1:0] d,
                             input logic [POS_W-1:0] p, input logic l);
    result_t r;
    r.status   = st;
    r.data     = d;
    r.position = p;
    r.last     = l;
    due_results.push_back(r);
  endtask

  // Mirror of the queue: head at index 0, results in emission order
  task automatic apply_op(input logic [FUNC_W-1:0] f, input logic signed [VAL_W-1:0] v);
    int hits;
    int seen;
    hits = 0;
    seen = 0;
    case (f)
      FUNC_ENQ: begin
        if (mirror_words.size() >= DEPTH) begin
          overflows++;
          push_result(ST_OVERFLOW, '0, '0, 1'b1);
        end else begin
          mirror_words.push_back(v);
          push_result(ST_OK, '0, '0, 1'b1);
        end
      end
      FUNC_DEQ: begin
        if (mirror_words.size() == 0) begin
          underflows++;
          push_result(ST_UNDERFLOW, '0, '0, 1'b1);
        end else begin
          push_result(ST_OK, mirror_words.pop_front(), '0, 1'b1);
        end
      end
      FUNC_SEARCH: begin
        foreach (mirror_words[i])
          if (mirror_words[i] == v) hits++;
        if (hits == 0) push_result(ST_NOMATCH, '0, '0, 1'b1);
        foreach (mirror_words[i])
          if (mirror_words[i] == v) begin
            seen++;
            push_result(ST_MATCH, mirror_words[i], POS_W'(i), seen == hits);
          end
        if (hits > widest_search) widest_search = hits;
      end
      default: ;
    endcase
  endtask

  // Driver: holds the item until its transfer, then idles for its gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.func  <= FUNC_ENQ;
      in_ch.value <= '0;
      idle_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_op(in_ch.func, in_ch.value);
        ops_done++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (idle_left != 0) begin
          idle_left--;
          in_ch.valid <= 1'b0;
        end else if (requests.size() != 0) begin
          next_rq = requests.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func  <= next_rq.func;
          in_ch.value <= next_rq.value;
          idle_left = next_rq.gap;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer, then decides how long to stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: status %0d data %0d position %0d last %0b",
                   $time, out_ch.status, out_ch.data, out_ch.position, out_ch.last);
        end else begin
          want = due_results.pop_front();
          if (out_ch.status !== want.status || out_ch.data !== want.data ||
              out_ch.position !== want.position || out_ch.last !== want.last) begin
            errors++;
            $display("%0t: mismatch: expected status %0d data %0d position %0d last %0b,",
                     $time, want.status, want.data, want.position, want.last,
                     " actual status %0d data %0d position %0d last %0b",
                     out_ch.status, out_ch.data, out_ch.position, out_ch.last);
          end
        end
        // one long hold-off early on, while the sender is still streaming
        if (results_checked == 30) stall_left = LONG_HOLD;
        else stall_left = idle_len(((results_checked / 80) % 3) == 1);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  initial begin
    logic signed [VAL_W-1:0] flat;
    int unsigned r;

    in_ch.valid  = 1'b0;
    in_ch.func   = FUNC_ENQ;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;

    word_pool[0] = WORD_MIN;
    word_pool[1] = WORD_MAX;
    word_pool[2] = '0;
    word_pool[3] = -1;
    for (int k = 4; k < 8; k++) word_pool[k] = $urandom;

    // directed: empty cases, extreme words, repeated keys, shifting on dequeue
    gen_calm = 1'b0;
    add_op(FUNC_SEARCH, '0);
    add_op(FUNC_DEQ, '0);
    add_op(FUNC_NONE, '1);
    add_op(FUNC_ENQ, WORD_MIN);
    add_op(FUNC_ENQ, WORD_MAX);
    add_op(FUNC_ENQ, '0);
    add_op(FUNC_ENQ, -1);
    add_op(FUNC_ENQ, WORD_MAX);
    add_op(FUNC_ENQ, WORD_MIN);
    add_op(FUNC_SEARCH, WORD_MAX);
    add_op(FUNC_SEARCH, WORD_MIN);
    add_op(FUNC_SEARCH, '0);
    add_op(FUNC_SEARCH, 32'sd12345);
    add_op(FUNC_NONE, '0);
    add_op(FUNC_DEQ, '1);
    add_op(FUNC_DEQ, '0);
    add_op(FUNC_SEARCH, WORD_MIN);
    repeat (5) add_op(FUNC_DEQ, '0);
    add_op(FUNC_SEARCH, -1);

    // mixed traffic, first half without gaps
    for (int k = 0; k < 16; k++) begin
      gen_calm = (k < 8);
      r = $urandom_range(0, 99);
      if (r < 40) add_op(FUNC_ENQ, pick_word());
      else if (r < 70) add_op(FUNC_DEQ, $urandom);
      else if (r < 95) add_op(FUNC_SEARCH, pick_word());
      else add_op(FUNC_NONE, $urandom);
    end

    // empty it, then fill with one word so that searches hit every position
    gen_calm = 1'b0;
    while (gen_fill != 0) add_op(FUNC_DEQ, $urandom);
    flat = $urandom;
    while (gen_fill < DEPTH) begin
      add_op(FUNC_ENQ, flat);
      if (gen_fill % 16 == 0) add_op(FUNC_SEARCH, flat);
    end
    add_op(FUNC_ENQ, pick_word());
    add_op(FUNC_ENQ, $urandom);
    add_op(FUNC_SEARCH, ~flat);
    add_op(FUNC_NONE, flat);

    // drain half way with searches and a few refills along the way
    for (int k = 0; gen_fill > DEPTH / 2; k++) begin
      gen_calm = (k < 20);
      r = $urandom_range(0, 99);
      if (r < 80) add_op(FUNC_DEQ, $urandom);
      else if (r < 85) add_op(FUNC_ENQ, pick_word());
      else if (r < 97) add_op(FUNC_SEARCH, ($urandom_range(0, 1) != 0) ? flat : pick_word());
      else add_op(FUNC_NONE, $urandom);
    end
    add_op(FUNC_DEQ, '0);
    add_op(FUNC_SEARCH, flat);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (requests.size() != 0 || in_ch.valid || due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d operations applied, %0d results checked (%0d overflows, %0d underflows)",
             ops_done, results_checked, overflows, underflows);
    $display("widest search returned %0d matches; %0d errors", widest_search, errors);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results still due", due_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule
